// ===== hdl/pdf_pkg.sv =====
// Package for the packet deframer: phase and status codes, register indexes,
// the result record and the sizes of the frame layout.
// No dependencies; every other file of the block uses it by scoped names.
package pdf_pkg;

    localparam int DATA_FRAMES = 12;
    localparam int MARKER_LEN  = 4;

    localparam int IDX_MAX = (DATA_FRAMES > MARKER_LEN) ? DATA_FRAMES : MARKER_LEN;
    localparam int IDX_W   = (IDX_MAX > 1) ? $clog2(IDX_MAX) : 1;

    localparam int BYTE_W    = 8;
    localparam int PAYLOAD_W = 24;
    localparam int BITSEL_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_HEAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd3;

    localparam logic [BYTE_W-1:0]   HEAD_RESET  = 8'h00;
    localparam logic [BYTE_W-1:0]   TAIL_RESET  = 8'hFF;
    localparam logic [BITSEL_W-1:0] UPPER_RESET = 3'd4;
    localparam logic [BITSEL_W-1:0] LOWER_RESET = 3'd3;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_NUMBER = 3'd1,
        PH_SIZE   = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHECK  = 3'd4,
        PH_INFO   = 3'd5,
        PH_TAIL   = 3'd6
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_ZERO  = 3'd1,
        ST_CHECK = 3'd2,
        ST_INFO  = 3'd3,
        ST_TAIL  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FOLD_OR  = 2'd0,
        FOLD_AND = 2'd1,
        FOLD_XOR = 2'd2
    } fold_t;

    typedef struct packed {
        status_t               status;
        logic [PAYLOAD_W-1:0]  payload;
        logic [BYTE_W-1:0]     number;
        logic [BYTE_W-1:0]     size;
        logic [BYTE_W-1:0]     check;
    } result_t;

endpackage

// ===== hdl/pdf_core.sv =====
// Deframer sequencer and datapath: phase register, frame counter, check fold
// and payload shifter, updated once per accepted frame byte.
// Depends on pdf_pkg.
module pdf_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [pdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pdf_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                          byte_fire,
    input  logic [pdf_pkg::BYTE_W-1:0]    byte_in,
    output logic                          res_push,
    output pdf_pkg::result_t              res_data
);

    localparam logic [pdf_pkg::IDX_W-1:0] DATA_LAST   = pdf_pkg::IDX_W'(pdf_pkg::DATA_FRAMES - 1);
    localparam logic [pdf_pkg::IDX_W-1:0] MARKER_LAST = pdf_pkg::IDX_W'(pdf_pkg::MARKER_LEN - 1);

    logic [pdf_pkg::BYTE_W-1:0]    head_reg;
    logic [pdf_pkg::BYTE_W-1:0]    tail_reg;
    logic [pdf_pkg::BITSEL_W-1:0]  upper_reg;
    logic [pdf_pkg::BITSEL_W-1:0]  lower_reg;

    pdf_pkg::phase_t               phase_reg, phase_next;
    logic [pdf_pkg::IDX_W-1:0]     idx_reg, idx_next;
    pdf_pkg::fold_t                fold_reg, fold_next;
    logic [pdf_pkg::BYTE_W-1:0]    acc_reg, acc_next;
    logic [pdf_pkg::PAYLOAD_W-1:0] shift_reg, shift_next;
    logic [pdf_pkg::BYTE_W-1:0]    number_reg, number_next;
    logic [pdf_pkg::BYTE_W-1:0]    size_reg, size_next;

    logic                          emit;
    pdf_pkg::status_t              emit_status;
    logic [pdf_pkg::BYTE_W-1:0]    folded;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= pdf_pkg::HEAD_RESET;
            tail_reg  <= pdf_pkg::TAIL_RESET;
            upper_reg <= pdf_pkg::UPPER_RESET;
            lower_reg <= pdf_pkg::LOWER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pdf_pkg::REG_HEAD:  head_reg  <= cfg_data;
                pdf_pkg::REG_TAIL:  tail_reg  <= cfg_data;
                pdf_pkg::REG_UPPER: upper_reg <= cfg_data[pdf_pkg::BITSEL_W-1:0];
                pdf_pkg::REG_LOWER: lower_reg <= cfg_data[pdf_pkg::BITSEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pdf_pkg::PH_HUNT;
            idx_reg    <= '0;
            fold_reg   <= pdf_pkg::FOLD_OR;
            acc_reg    <= '0;
            shift_reg  <= '0;
            number_reg <= '0;
            size_reg   <= '0;
        end
        else if (byte_fire)
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            fold_reg   <= fold_next;
            acc_reg    <= acc_next;
            shift_reg  <= shift_next;
            number_reg <= number_next;
            size_reg   <= size_next;
        end
    end

    always_comb
    begin
        case (fold_reg)
            pdf_pkg::FOLD_OR:  folded = acc_reg | byte_in;
            pdf_pkg::FOLD_AND: folded = acc_reg & byte_in;
            default:           folded = acc_reg ^ byte_in;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        fold_next   = fold_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        number_next = number_reg;
        size_next   = size_reg;
        emit        = 1'b0;
        emit_status = pdf_pkg::ST_OK;

        unique case (phase_reg)
            pdf_pkg::PH_HUNT:
            begin
                if (byte_in == head_reg)
                begin
                    if (idx_reg == MARKER_LAST)
                    begin
                        phase_next = pdf_pkg::PH_NUMBER;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    idx_next = '0;
                end
            end
            pdf_pkg::PH_NUMBER:
            begin
                number_next = byte_in;
                phase_next  = pdf_pkg::PH_SIZE;
            end
            pdf_pkg::PH_SIZE:
            begin
                size_next  = byte_in;
                phase_next = pdf_pkg::PH_DATA;
                idx_next   = '0;
                fold_next  = pdf_pkg::FOLD_OR;
                acc_next   = '0;
                shift_next = '0;
            end
            pdf_pkg::PH_DATA:
            begin
                if (byte_in == '0)
                begin
                    emit        = 1'b1;
                    emit_status = pdf_pkg::ST_ZERO;
                end
                else
                begin
                    shift_next = {shift_reg[pdf_pkg::PAYLOAD_W-3:0],
                                  byte_in[upper_reg], byte_in[lower_reg]};
                    acc_next   = folded;
                    case (fold_reg)
                        pdf_pkg::FOLD_OR:  fold_next = pdf_pkg::FOLD_AND;
                        pdf_pkg::FOLD_AND: fold_next = pdf_pkg::FOLD_XOR;
                        default:           fold_next = pdf_pkg::FOLD_OR;
                    endcase
                    if (idx_reg == DATA_LAST)
                    begin
                        phase_next = pdf_pkg::PH_CHECK;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            pdf_pkg::PH_CHECK:
            begin
                if (byte_in != acc_reg)
                begin
                    emit        = 1'b1;
                    emit_status = pdf_pkg::ST_CHECK;
                end
                else
                begin
                    phase_next = pdf_pkg::PH_INFO;
                end
            end
            pdf_pkg::PH_INFO:
            begin
                if (byte_in != (number_reg ^ size_reg))
                begin
                    emit        = 1'b1;
                    emit_status = pdf_pkg::ST_INFO;
                end
                else
                begin
                    phase_next = pdf_pkg::PH_TAIL;
                    idx_next   = '0;
                end
            end
            pdf_pkg::PH_TAIL:
            begin
                if (byte_in != tail_reg)
                begin
                    emit        = 1'b1;
                    emit_status = pdf_pkg::ST_TAIL;
                end
                else if (idx_reg == MARKER_LAST)
                begin
                    emit        = 1'b1;
                    emit_status = pdf_pkg::ST_OK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                phase_next = pdf_pkg::PH_HUNT;
                idx_next   = '0;
                acc_next   = '0;
                shift_next = '0;
            end
        endcase

        // any result drops the packet and restarts the head search
        if (emit)
        begin
            phase_next = pdf_pkg::PH_HUNT;
            idx_next   = '0;
            acc_next   = '0;
            shift_next = '0;
        end
    end

    assign res_push         = byte_fire && emit;
    assign res_data.status  = emit_status;
    assign res_data.payload = (emit_status == pdf_pkg::ST_OK) ? shift_reg : '0;
    assign res_data.number  = number_reg;
    assign res_data.size    = size_reg;
    assign res_data.check   = acc_reg;

    a_hunt_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (phase_reg == pdf_pkg::PH_HUNT) && (idx_reg == '0))
        else $error("phase did not return to hunting after a result");

    a_ok_only_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.status == pdf_pkg::ST_OK) |-> (phase_reg == pdf_pkg::PH_TAIL))
        else $error("ok result outside the tail phase");

    a_zero_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.status == pdf_pkg::ST_ZERO) |->
            (phase_reg == pdf_pkg::PH_DATA && byte_in == '0))
        else $error("zero frame result without a zero data frame");

endmodule

// ===== hdl/pdf_result_buf.sv =====
// Two-slot result queue: an output register plus a skid slot, so the
// byte side keeps running while a result waits. Depends on pdf_pkg.
module pdf_result_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pdf_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output pdf_pkg::result_t out_data
);

    logic             head_v_reg, head_v_next;
    logic             skid_v_reg, skid_v_next;
    pdf_pkg::result_t head_reg, head_next;
    pdf_pkg::result_t skid_reg, skid_next;
    logic             pop;

    assign pop       = head_v_reg && out_ready;
    assign full      = head_v_reg && skid_v_reg;
    assign out_valid = head_v_reg;
    assign out_data  = head_reg;

    always_comb
    begin
        head_v_next = head_v_reg;
        skid_v_next = skid_v_reg;
        head_next   = head_reg;
        skid_next   = skid_reg;
        if (skid_v_reg)
        begin
            // advance the skid slot into the output register
            if (pop)
            begin
                head_next   = skid_reg;
                skid_v_next = 1'b0;
            end
        end
        else if (head_v_reg && !pop)
        begin
            if (push)
            begin
                skid_next   = push_data;
                skid_v_next = 1'b1;
            end
        end
        else
        begin
            head_v_next = push;
            if (push)
            begin
                head_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            head_v_reg <= head_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result pushed into a full queue");

    a_skid_implies_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> head_v_reg)
        else $error("skid slot holds a result while output register is empty");

    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_v_reg) |=> (head_v_reg && head_reg == $past(skid_reg)))
        else $error("skid result lost on pop");

endmodule

// ===== hdl/packet_deframer_unit.sv =====
// Top level of the packet deframer: byte channel in, status channel out,
// plain configuration write port. Depends on pdf_pkg, pdf_core, pdf_result_buf.
//
// The unit takes one frame byte per clock cycle while in_ready is high; each
// accepted byte updates the phase, counter, check fold and payload shifter in
// that same edge. A byte ending a packet (last tail byte or first failing byte)
// yields one status transaction, on out_valid the cycle after if the queue is
// empty. Results go into a two-slot queue; in_ready is low only while both slots
// hold untaken results. A full packet is 4 head, 2 header, 12 data, 1 check,
// 1 info and 4 tail bytes. Registers must be written with cfg_write only while
// the unit is idle; the block does not enforce it. No reset sweep or warm-up.
module packet_deframer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [pdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pdf_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pdf_pkg::BYTE_W-1:0]    frame_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pdf_pkg::STATUS_W-1:0]  status,
    output logic [pdf_pkg::PAYLOAD_W-1:0] payload,
    output logic [pdf_pkg::BYTE_W-1:0]    packet_number,
    output logic [pdf_pkg::BYTE_W-1:0]    packet_size,
    output logic [pdf_pkg::BYTE_W-1:0]    computed_check
);

    logic             byte_fire;
    logic             res_push;
    logic             full;
    pdf_pkg::result_t res_data;
    pdf_pkg::result_t out_data;

    assign in_ready  = !full;
    assign byte_fire = in_valid && in_ready;

    pdf_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_fire (byte_fire),
        .byte_in   (frame_byte),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    pdf_result_buf u_result_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .full      (full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign status         = out_data.status;
    assign payload        = out_data.payload;
    assign packet_number  = out_data.number;
    assign packet_size    = out_data.size;
    assign computed_check = out_data.check;

endmodule

// ===== dv/tb_packet_deframer_unit.sv =====
// Self-checking testbench for packet_deframer_unit: drives frame bytes and register
// writes, predicts each status transaction and compares it field by field.
// Depends on pdf_pkg and the RTL of packet_deframer_unit.
module tb_packet_deframer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {PK_OK, PK_ZERO, PK_CHECK, PK_INFO, PK_TAIL, PK_HEAD} packet_kind_t;
    typedef logic [pdf_pkg::PAYLOAD_W-1:0] word_t;

    // Tracks the deframer state, holds the status transactions still owed by the DUT
    class deframe_scoreboard;
        pdf_pkg::phase_t               phase;
        logic [3:0]                    idx;
        logic [7:0]                    fold;
        logic [pdf_pkg::PAYLOAD_W-1:0] shift;
        logic [7:0]                    num;
        logic [7:0]                    sz;
        logic [7:0]                    head;
        logic [7:0]                    tail;
        logic [2:0]                    upper_sel;
        logic [2:0]                    lower_sel;
        pdf_pkg::result_t              pending_status[$];
        int                            errors;
        int                            checked;
        int                            per_status[5];

        function new();
            head = pdf_pkg::HEAD_RESET;
            tail = pdf_pkg::TAIL_RESET;
            upper_sel = pdf_pkg::UPPER_RESET;
            lower_sel = pdf_pkg::LOWER_RESET;
            num = '0;
            sz = '0;
            errors = 0;
            checked = 0;
            restart();
        endfunction

        function void restart();
            phase = pdf_pkg::PH_HUNT;
            idx = '0;
            fold = '0;
            shift = '0;
        endfunction

        function void set_reg(logic [pdf_pkg::CFG_IDX_W-1:0] r, logic [7:0] v);
            case (r)
                pdf_pkg::REG_HEAD:  head = v;
                pdf_pkg::REG_TAIL:  tail = v;
                pdf_pkg::REG_UPPER: upper_sel = v[2:0];
                pdf_pkg::REG_LOWER: lower_sel = v[2:0];
                default: ;
            endcase
        endfunction

        function void close_packet(pdf_pkg::status_t st);
            pdf_pkg::result_t r;
            r.status = st;
            r.payload = (st == pdf_pkg::ST_OK) ? shift : '0;
            r.number = num;
            r.size = sz;
            r.check = fold;
            pending_status = {pending_status, r};
            restart();
        endfunction

        // Advance the deframer by one accepted frame byte
        function void take_byte(logic [7:0] b);
            case (phase)
                pdf_pkg::PH_HUNT:
                    if (b != head)
                        idx = '0;
                    else if (int'(idx) + 1 >= pdf_pkg::MARKER_LEN)
                    begin
                        phase = pdf_pkg::PH_NUMBER;
                        idx = '0;
                    end
                    else
                        idx = idx + 1'b1;
                pdf_pkg::PH_NUMBER:
                begin
                    num = b;
                    phase = pdf_pkg::PH_SIZE;
                end
                pdf_pkg::PH_SIZE:
                begin
                    sz = b;
                    phase = pdf_pkg::PH_DATA;
                    idx = '0;
                    fold = '0;
                    shift = '0;
                end
                pdf_pkg::PH_DATA:
                    if (b == 8'h00)
                        close_packet(pdf_pkg::ST_ZERO);
                    else
                    begin
                        shift = {shift[pdf_pkg::PAYLOAD_W-3:0], b[upper_sel], b[lower_sel]};
                        case (pdf_pkg::fold_t'(idx % 3))
                            pdf_pkg::FOLD_OR:  fold = fold | b;
                            pdf_pkg::FOLD_AND: fold = fold & b;
                            default:           fold = fold ^ b;
                        endcase
                        if (int'(idx) + 1 >= pdf_pkg::DATA_FRAMES)
                        begin
                            phase = pdf_pkg::PH_CHECK;
                            idx = '0;
                        end
                        else
                            idx = idx + 1'b1;
                    end
                pdf_pkg::PH_CHECK:
                    if (b != fold)
                        close_packet(pdf_pkg::ST_CHECK);
                    else
                        phase = pdf_pkg::PH_INFO;
                pdf_pkg::PH_INFO:
                    if (b != (num ^ sz))
                        close_packet(pdf_pkg::ST_INFO);
                    else
                    begin
                        phase = pdf_pkg::PH_TAIL;
                        idx = '0;
                    end
                pdf_pkg::PH_TAIL:
                    if (b != tail)
                        close_packet(pdf_pkg::ST_TAIL);
                    else if (int'(idx) + 1 >= pdf_pkg::MARKER_LEN)
                        close_packet(pdf_pkg::ST_OK);
                    else
                        idx = idx + 1'b1;
                default:
                    restart();
            endcase
        endfunction

        function void compare(string name, word_t e, word_t a);
            if (a !== e)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_status(logic [pdf_pkg::STATUS_W-1:0] st,
                                   logic [pdf_pkg::PAYLOAD_W-1:0] pl,
                                   logic [7:0] n, logic [7:0] s, logic [7:0] c);
            pdf_pkg::result_t e;
            if (pending_status.size() == 0)
            begin
                $error("status transaction with nothing outstanding: status %0d", st);
                errors++;
                return;
            end
            e = pending_status.pop_front();
            checked++;
            if (int'(e.status) < 5)
                per_status[e.status]++;
            compare("status", word_t'(e.status), word_t'(st));
            compare("payload", e.payload, pl);
            compare("packet_number", word_t'(e.number), word_t'(n));
            compare("packet_size", word_t'(e.size), word_t'(s));
            compare("computed_check", word_t'(e.check), word_t'(c));
        endfunction
    endclass

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_write = 1'b0;
    logic [pdf_pkg::CFG_IDX_W-1:0]         cfg_index = '0;
    logic [pdf_pkg::BYTE_W-1:0]            cfg_data = '0;
    logic                                  in_valid = 1'b0;
    logic                                  in_ready;
    logic [pdf_pkg::BYTE_W-1:0]            frame_byte = '0;
    logic                                  out_valid;
    logic                                  out_ready = 1'b0;
    logic [pdf_pkg::STATUS_W-1:0]          status;
    logic [pdf_pkg::PAYLOAD_W-1:0]         payload;
    logic [pdf_pkg::BYTE_W-1:0]            packet_number;
    logic [pdf_pkg::BYTE_W-1:0]            packet_size;
    logic [pdf_pkg::BYTE_W-1:0]            computed_check;

    deframe_scoreboard sb = new();
    int                sent = 0;
    int                settings_run = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;

    packet_deframer_unit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .frame_byte     (frame_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .payload        (payload),
        .packet_number  (packet_number),
        .packet_size    (packet_size),
        .computed_check (computed_check)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: one long hold-off to back the block up, one stretch always ready
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_status(status, payload, packet_number, packet_size, computed_check);
            if (!hold_done && sent >= 500)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (sent >= 900 && sent < 1150)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 33);
        end
    end

    function automatic logic [7:0] other_than(logic [7:0] v);
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == v);
        return b;
    endfunction

    function automatic logic [7:0] header_value();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] data_value();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return 8'hFF;
        if (r == 1)
            return 8'h01;
        return 8'($urandom_range(255, 1));
    endfunction

    task automatic send_byte(logic [7:0] b);
        while (!(sent >= 900 && sent < 1150) && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_byte(b);
        sent++;
    endtask

    task automatic write_reg(logic [pdf_pkg::CFG_IDX_W-1:0] r, logic [7:0] v);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        @(posedge clk);
        sb.set_reg(r, v);
    endtask

    // Upper bits of the bit-select writes are junk that the block must drop
    task automatic program_regs(logic [7:0] h, logic [7:0] t, logic [2:0] u, logic [2:0] l);
        write_reg(pdf_pkg::REG_HEAD, h);
        write_reg(pdf_pkg::REG_TAIL, t);
        write_reg(pdf_pkg::REG_UPPER, {5'($urandom), u});
        write_reg(pdf_pkg::REG_LOWER, {5'($urandom), l});
        cfg_write <= 1'b0;
        settings_run++;
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (sb.pending_status.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    // Check bytes come from the tracked fold and info bytes from the tracked number ^ size, so that good packets pass
    task automatic send_packet(packet_kind_t kind);
        int cut;
        cut = $urandom_range(pdf_pkg::MARKER_LEN - 1);
        for (int i = 0; i < pdf_pkg::MARKER_LEN; i++)
        begin
            if (kind == PK_HEAD && i == cut)
            begin
                send_byte(other_than(sb.head));
                return;
            end
            send_byte(sb.head);
        end
        send_byte(header_value());
        send_byte(header_value());
        cut = $urandom_range(pdf_pkg::DATA_FRAMES - 1);
        for (int i = 0; i < pdf_pkg::DATA_FRAMES; i++)
        begin
            if (kind == PK_ZERO && i == cut)
            begin
                send_byte(8'h00);
                return;
            end
            send_byte(data_value());
        end
        if (kind == PK_CHECK)
        begin
            send_byte(other_than(sb.fold));
            return;
        end
        send_byte(sb.fold);
        if (kind == PK_INFO)
        begin
            send_byte(other_than(sb.num ^ sb.sz));
            return;
        end
        send_byte(sb.num ^ sb.sz);
        cut = $urandom_range(pdf_pkg::MARKER_LEN - 1);
        for (int i = 0; i < pdf_pkg::MARKER_LEN; i++)
        begin
            if (kind == PK_TAIL && i == cut)
            begin
                send_byte(other_than(sb.tail));
                return;
            end
            send_byte(sb.tail);
        end
    endtask

    task automatic random_packets(int count);
        int target;
        int r;
        packet_kind_t kind;
        target = sent + count;
        while (sent < target)
        begin
            if ($urandom_range(9) < 2)
                repeat ($urandom_range(3, 1)) send_byte(other_than(sb.head));
            r = $urandom_range(99);
            if (r < 50)
                kind = PK_OK;
            else if (r < 60)
                kind = PK_ZERO;
            else if (r < 70)
                kind = PK_CHECK;
            else if (r < 80)
                kind = PK_INFO;
            else if (r < 90)
                kind = PK_TAIL;
            else
                kind = PK_HEAD;
            send_packet(kind);
        end
        settle();
    endtask

    initial
    begin
        logic [7:0] edge_frames[pdf_pkg::DATA_FRAMES];
        logic [7:0] shared;
        edge_frames = '{8'hFF, 8'h01, 8'h80, 8'hFF, 8'h7F, 8'h55,
                        8'hAA, 8'hFE, 8'h01, 8'hFF, 8'hFF, 8'h80};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settings_run = 1;

        // Broken head, then one good packet with extreme header and data values
        send_byte(sb.head);
        send_byte(sb.head);
        send_byte(8'h5A);
        repeat (pdf_pkg::MARKER_LEN) send_byte(sb.head);
        send_byte(8'hFF);
        send_byte(8'h00);
        foreach (edge_frames[i])
            send_byte(edge_frames[i]);
        send_byte(sb.fold);
        send_byte(sb.num ^ sb.sz);
        repeat (pdf_pkg::MARKER_LEN) send_byte(sb.tail);
        random_packets(280);

        program_regs(8'hFF, 8'h00, 3'd7, 3'd0);
        random_packets(305);
        program_regs(8'($urandom), 8'($urandom), 3'd0, 3'd7);
        random_packets(305);
        shared = 8'($urandom);
        program_regs(shared, shared, 3'd5, 3'd5);
        random_packets(305);
        program_regs(8'($urandom), 8'($urandom), 3'($urandom), 3'($urandom));
        random_packets(305);

        if (sb.pending_status.size() != 0)
        begin
            $error("%0d status transactions never arrived", sb.pending_status.size());
            sb.errors++;
        end
        $display("Sent %0d frame bytes under %0d register settings; checked %0d results",
                 sent, settings_run, sb.checked);
        $display("  ok %0d, zero frame %0d, check %0d, info %0d, tail %0d",
                 sb.per_status[pdf_pkg::ST_OK], sb.per_status[pdf_pkg::ST_ZERO],
                 sb.per_status[pdf_pkg::ST_CHECK], sb.per_status[pdf_pkg::ST_INFO],
                 sb.per_status[pdf_pkg::ST_TAIL]);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pdf_pkg.sv
hdl/pdf_core.sv
hdl/pdf_result_buf.sv
hdl/packet_deframer_unit.sv
dv/tb_packet_deframer_unit.sv
